>>> rtl/core/bis_pkg.sv
package bis_pkg;

  // Limits of the configuration registers
  localparam int SRC_MAX = 256;
  localparam int DST_MAX = 4096;
  localparam int CH_MAX  = 4;

  // Source store: byte addressed, split into four byte banks by the low address bits
  localparam int STORE_AW   = 18;
  localparam int BANKS      = 4;
  localparam int BANK_AW    = STORE_AW - 2;
  localparam int BANK_DEPTH = 1 << BANK_AW;

  // Corners of one blend and the shape of the iterative dividers
  localparam int CORNERS     = 4;
  localparam int QUOT_W      = 8;
  localparam int DIV_PER_CYC = 2;
  localparam int DIV_CYCLES  = QUOT_W / DIV_PER_CYC;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_CHANNELS   = 3'd4
  } cfg_idx_t;

endpackage

>>> rtl/core/bis_ram.sv
module bis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port: write or registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/bilinear_image_scaler.sv
// Channel   | Direction | Handshake            | Payload
// cfg       | in        | cfg_we               | cfg_index, cfg_data
// input     | in        | in_valid / in_stall  | command, src_index, src_byte, dst_x, dst_y
// output    | out       | out_valid / out_stall| chan0, chan1, chan2, chan3
//
// A load passes two stages and sustains one per cycle unless a compute holds the memory stage.
// A compute passes a coordinate divider, a memory stage (one corner
// read per cycle from four byte banks, plus the read latency) and a blend
// divider; each stage holds one transaction at a time, so a new pixel is taken
// once the one before it leaves the coordinate stage.
// Reset clears all control state and returns the configuration to its defaults; the source store is not cleared.
// out_stall holds the output register; in_stall is high while the coordinate stage
// holds a transaction that cannot move on, which includes every divide cycle.
module bilinear_image_scaler (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [17:0] src_index,
  input  logic [7:0]  src_byte,
  input  logic [11:0] dst_x,
  input  logic [11:0] dst_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  chan0,
  output logic [7:0]  chan1,
  output logic [7:0]  chan2,
  output logic [7:0]  chan3
);

  // Configuration registers
  logic [8:0]  src_width;
  logic [8:0]  src_height;
  logic [12:0] dst_width;
  logic [12:0] dst_height;
  logic [2:0]  channels;
  logic [23:0] cfg_prod;

  // Clamped geometry
  logic [7:0]  sw;
  logic [7:0]  sh;
  logic [11:0] dw;
  logic [11:0] dh;
  logic [2:0]  nc;
  logic [8:0]  src_pix_w;

  // Coordinate stage
  logic                 a_valid;
  bis_pkg::cmd_t        a_cmd;
  logic [2:0]           a_step;
  logic [11:0]          a_rx;
  logic [7:0]           a_nx;
  logic [11:0]          a_ry;
  logic [7:0]           a_ny;
  logic [17:0]          a_addr;
  logic [7:0]           a_byte;
  logic [11:0]          rx_next;
  logic [7:0]           nx_next;
  logic [11:0]          ry_next;
  logic [7:0]           ny_next;
  logic [11:0]          jx;
  logic [11:0]          iy;
  logic [19:0]          numx;
  logic [19:0]          numy;
  logic                 accept;
  logic                 a_move;
  logic                 a_free;

  // Transfer values into the memory stage
  logic [7:0]  x1_val;
  logic [7:0]  y1_val;
  logic [11:0] wx0;
  logic [11:0] wy0;
  logic [23:0] w_val [bis_pkg::CORNERS];

  // Memory stage
  logic                 b_valid;
  bis_pkg::cmd_t        b_cmd;
  logic [2:0]           b_cnt;
  logic [7:0]           b_x0;
  logic [7:0]           b_x1;
  logic [15:0]          b_row0;
  logic [15:0]          b_row1;
  logic [23:0]          b_w   [bis_pkg::CORNERS];
  logic [31:0]          b_acc [bis_pkg::CH_MAX];
  logic [17:0]          b_addr;
  logic [7:0]           b_byte;
  logic                 rd_vld;
  logic [1:0]           rd_k;
  logic [1:0]           rd_rot;
  logic                 b_issue;
  logic                 b_move;
  logic                 b_to_c;
  logic                 b_free;
  logic                 b_load;
  logic [15:0]          pix;
  logic [17:0]          base;
  logic [23:0]          w_sel;
  logic [7:0]           rbyte   [bis_pkg::CH_MAX];
  logic [31:0]          acc_add [bis_pkg::CH_MAX];
  logic [31:0]          sum_out [bis_pkg::CH_MAX];

  // Bank ports
  logic                        ram_we   [bis_pkg::BANKS];
  logic [bis_pkg::BANK_AW-1:0] ram_addr [bis_pkg::BANKS];
  logic [7:0]                  ram_q    [bis_pkg::BANKS];

  // Blend divider stage
  logic        c_valid;
  logic [2:0]  c_step;
  logic [23:0] c_r [bis_pkg::CH_MAX];
  logic [7:0]  c_n [bis_pkg::CH_MAX];
  logic [23:0] cr_next [bis_pkg::CH_MAX];
  logic [7:0]  cn_next [bis_pkg::CH_MAX];
  logic        c_move;
  logic        c_free;

  // Output register
  logic       o_valid;
  logic [7:0] o_chan [bis_pkg::CH_MAX];
  logic       o_free;

  // Write configuration; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= 9'(bis_pkg::SRC_MAX);
      src_height <= 9'(bis_pkg::SRC_MAX);
      dst_width  <= 13'd256;
      dst_height <= 13'd256;
      channels   <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        bis_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data[8:0];
        bis_pkg::REG_SRC_HEIGHT: src_height <= cfg_data[8:0];
        bis_pkg::REG_DST_WIDTH:  dst_width  <= cfg_data;
        bis_pkg::REG_DST_HEIGHT: dst_height <= cfg_data;
        bis_pkg::REG_CHANNELS:   channels   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes into their legal ranges
  always_comb begin
    if (src_width == 9'd0) begin
      sw = 8'd0;
    end else if (src_width > 9'(bis_pkg::SRC_MAX)) begin
      sw = 8'(bis_pkg::SRC_MAX - 1);
    end else begin
      sw = 8'(src_width - 9'd1);
    end
    if (src_height == 9'd0) begin
      sh = 8'd0;
    end else if (src_height > 9'(bis_pkg::SRC_MAX)) begin
      sh = 8'(bis_pkg::SRC_MAX - 1);
    end else begin
      sh = 8'(src_height - 9'd1);
    end
    if (dst_width < 13'd2) begin
      dw = 12'd1;
    end else if (dst_width > 13'(bis_pkg::DST_MAX)) begin
      dw = 12'(bis_pkg::DST_MAX - 1);
    end else begin
      dw = 12'(dst_width - 13'd1);
    end
    if (dst_height < 13'd2) begin
      dh = 12'd1;
    end else if (dst_height > 13'(bis_pkg::DST_MAX)) begin
      dh = 12'(bis_pkg::DST_MAX - 1);
    end else begin
      dh = 12'(dst_height - 13'd1);
    end
    if (channels == 3'd0) begin
      nc = 3'd1;
    end else if (channels > 3'(bis_pkg::CH_MAX)) begin
      nc = 3'(bis_pkg::CH_MAX);
    end else begin
      nc = channels;
    end
    src_pix_w = {1'b0, sw} + 9'd1;
  end

  // Hold the blend normalizer
  always_ff @(posedge clk) begin
    cfg_prod <= 24'(dw) * 24'(dh);
  end

  // Saturate coordinates and scale them
  always_comb begin
    jx   = (dst_x > dw) ? dw : dst_x;
    iy   = (dst_y > dh) ? dh : dst_y;
    numx = 20'(jx) * 20'(sw);
    numy = 20'(iy) * 20'(sh);
  end

  // Advance both coordinate divisions by two quotient bits
  always_comb begin
    logic [12:0] tx;
    logic [12:0] ty;
    rx_next = a_rx;
    nx_next = a_nx;
    ry_next = a_ry;
    ny_next = a_ny;
    for (int s = 0; s < bis_pkg::DIV_PER_CYC; s++) begin
      tx = {rx_next, nx_next[7]};
      if (tx >= {1'b0, dw}) begin
        rx_next = 12'(tx - {1'b0, dw});
        nx_next = {nx_next[6:0], 1'b1};
      end else begin
        rx_next = tx[11:0];
        nx_next = {nx_next[6:0], 1'b0};
      end
      ty = {ry_next, ny_next[7]};
      if (ty >= {1'b0, dh}) begin
        ry_next = 12'(ty - {1'b0, dh});
        ny_next = {ny_next[6:0], 1'b1};
      end else begin
        ry_next = ty[11:0];
        ny_next = {ny_next[6:0], 1'b0};
      end
    end
  end

  // Stage handshakes
  assign o_free   = !o_valid || !out_stall;
  assign c_move   = c_valid && (c_step == 3'(bis_pkg::DIV_CYCLES)) && o_free;
  assign c_free   = !c_valid || c_move;
  assign b_load   = b_valid && (b_cmd == bis_pkg::CMD_LOAD);
  assign b_to_c   = b_valid && (b_cmd == bis_pkg::CMD_COMPUTE)
                    && (b_cnt == 3'(bis_pkg::CORNERS)) && c_free;
  assign b_move   = b_load || b_to_c;
  assign b_free   = !b_valid || b_move;
  assign a_move   = a_valid && (a_step == 3'(bis_pkg::DIV_CYCLES)) && b_free;
  assign a_free   = !a_valid || a_move;
  assign in_stall = !a_free;
  assign accept   = in_valid && !in_stall;

  // Coordinate stage: take the transaction, then iterate the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_step  <= 3'd0;
    end else if (accept) begin
      a_valid <= 1'b1;
      a_cmd   <= bis_pkg::cmd_t'(command);
      a_step  <= (command == bis_pkg::CMD_COMPUTE) ? 3'd0 : 3'(bis_pkg::DIV_CYCLES);
      a_rx    <= numx[19:8];
      a_nx    <= numx[7:0];
      a_ry    <= numy[19:8];
      a_ny    <= numy[7:0];
      a_addr  <= src_index;
      a_byte  <= src_byte;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end else if (a_valid && (a_step < 3'(bis_pkg::DIV_CYCLES))) begin
      a_step <= a_step + 3'd1;
      a_rx   <= rx_next;
      a_nx   <= nx_next;
      a_ry   <= ry_next;
      a_ny   <= ny_next;
    end
  end

  // Neighbour coordinates and corner weights
  always_comb begin
    x1_val   = (a_rx == 12'd0) ? a_nx : a_nx + 8'd1;
    y1_val   = (a_ry == 12'd0) ? a_ny : a_ny + 8'd1;
    wx0      = dw - a_rx;
    wy0      = dh - a_ry;
    w_val[0] = 24'(wx0) * 24'(wy0);
    w_val[1] = 24'(a_rx) * 24'(wy0);
    w_val[2] = 24'(wx0) * 24'(a_ry);
    w_val[3] = 24'(a_rx) * 24'(a_ry);
  end

  // Corner address: pixel index times bytes per pixel
  always_comb begin
    b_issue = b_valid && (b_cmd == bis_pkg::CMD_COMPUTE) && (b_cnt < 3'(bis_pkg::CORNERS));
    pix     = (b_cnt[1] ? b_row1 : b_row0) + 16'(b_cnt[0] ? b_x1 : b_x0);
    base    = 18'(18'(pix) * 18'(nc));
  end

  // Steer bank ports: a load writes one bank, a corner read spans all four
  always_comb begin
    logic [1:0]  off;
    logic [17:0] ab;
    for (int b = 0; b < bis_pkg::BANKS; b++) begin
      off = 2'(b) - base[1:0];
      ab  = base + 18'(off);
      ram_we[b] = b_load && (b_addr[1:0] == 2'(b));
      ram_addr[b] = b_load ? b_addr[17:2] : ab[17:2];
    end
  end

  for (genvar g = 0; g < bis_pkg::BANKS; g++) begin : g_bank
    bis_ram #(
      .WIDTH (8),
      .DEPTH (bis_pkg::BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[g]),
      .re    (b_issue),
      .addr  (ram_addr[g]),
      .wdata (b_byte),
      .rdata (ram_q[g])
    );
  end

  // Rotate returned bytes into channel order and weight them
  always_comb begin
    w_sel = b_w[rd_k];
    for (int k = 0; k < bis_pkg::CH_MAX; k++) begin
      rbyte[k]   = ram_q[2'(rd_rot + 2'(k))];
      acc_add[k] = b_acc[k] + 32'(rbyte[k]) * 32'(w_sel);
      sum_out[k] = rd_vld ? acc_add[k] : b_acc[k];
    end
  end

  // Memory stage: write a load, or issue four corner reads and accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_cnt   <= 3'd0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= b_issue;
      if (b_issue) begin
        rd_k   <= b_cnt[1:0];
        rd_rot <= base[1:0];
        b_cnt  <= b_cnt + 3'd1;
      end
      if (rd_vld) begin
        b_acc <= acc_add;
      end
      if (a_move) begin
        b_valid <= 1'b1;
        b_cmd   <= a_cmd;
        b_cnt   <= 3'd0;
        b_x0    <= a_nx;
        b_x1    <= x1_val;
        b_row0  <= 16'(17'(a_ny) * 17'(src_pix_w));
        b_row1  <= 16'(17'(y1_val) * 17'(src_pix_w));
        b_w     <= w_val;
        b_addr  <= a_addr;
        b_byte  <= a_byte;
        for (int k = 0; k < bis_pkg::CH_MAX; k++) begin
          b_acc[k] <= 32'(cfg_prod >> 1);
        end
      end else if (b_move) begin
        b_valid <= 1'b0;
      end
    end
  end

  // Advance the per-channel normalizing divisions by two quotient bits
  always_comb begin
    logic [24:0] t;
    for (int k = 0; k < bis_pkg::CH_MAX; k++) begin
      cr_next[k] = c_r[k];
      cn_next[k] = c_n[k];
      for (int s = 0; s < bis_pkg::DIV_PER_CYC; s++) begin
        t = {cr_next[k], cn_next[k][7]};
        if (t >= {1'b0, cfg_prod}) begin
          cr_next[k] = 24'(t - {1'b0, cfg_prod});
          cn_next[k] = {cn_next[k][6:0], 1'b1};
        end else begin
          cr_next[k] = t[23:0];
          cn_next[k] = {cn_next[k][6:0], 1'b0};
        end
      end
    end
  end

  // Blend divider stage
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      c_step  <= 3'd0;
    end else if (b_to_c) begin
      c_valid <= 1'b1;
      c_step  <= 3'd0;
      for (int k = 0; k < bis_pkg::CH_MAX; k++) begin
        c_r[k] <= sum_out[k][31:8];
        c_n[k] <= sum_out[k][7:0];
      end
    end else if (c_move) begin
      c_valid <= 1'b0;
    end else if (c_valid && (c_step < 3'(bis_pkg::DIV_CYCLES))) begin
      c_step <= c_step + 3'd1;
      c_r    <= cr_next;
      c_n    <= cn_next;
    end
  end

  // Output register; unused channels read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (c_move) begin
      o_valid <= 1'b1;
      for (int k = 0; k < bis_pkg::CH_MAX; k++) begin
        o_chan[k] <= (3'(k) < nc) ? c_n[k] : 8'd0;
      end
    end else if (!out_stall) begin
      o_valid <= 1'b0;
    end
  end

  assign out_valid = o_valid;
  assign chan0     = o_chan[0];
  assign chan1     = o_chan[1];
  assign chan2     = o_chan[2];
  assign chan3     = o_chan[3];

endmodule

>>> rtl/core/bis_check.sv
module bis_check (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [12:0] cfg_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic        command,
  input logic [17:0] src_index,
  input logic [7:0]  src_byte,
  input logic [11:0] dst_x,
  input logic [11:0] dst_y,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  chan0,
  input logic [7:0]  chan1,
  input logic [7:0]  chan2,
  input logic [7:0]  chan3
);

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // Reset empties every stage, so input is taken at once
  a_rst_ready: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

  // No transaction completes its pipeline as reset is released
  a_rst_latency: assert property (@(posedge clk) rst ##1 !rst |=> !out_valid)
    else $error("result appeared too early after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(chan0) && $stable(chan1)
                               && $stable(chan2) && $stable(chan3))
    else $error("stalled result changed");

endmodule

bind bilinear_image_scaler bis_check u_bis_check (.*);

>>> tb/bilinear_image_scaler_tb.sv
module bilinear_image_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [3:0][7:0] pixel_t;

  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;

  // Expected pixel store and mismatch accounting
  class pixel_scoreboard;
    pixel_t pending[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function void note_pixel(pixel_t px);
      pending.push_back(px);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected pixel %h", got));
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < bis_pkg::CH_MAX; k++) begin
        if (got[k] !== want[k])
          report($sformatf("chan%0d got %0d want %0d", k, got[k], want[k]));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        command;
  logic [17:0] src_index;
  logic [7:0]  src_byte;
  logic [11:0] dst_x;
  logic [11:0] dst_y;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  chan0, chan1, chan2, chan3;

  bilinear_image_scaler uut (.*);

  pixel_scoreboard board = new();

  // Shadow of the source store and the registers
  logic [7:0]  image_mem [0:(1 << bis_pkg::STORE_AW) - 1];
  logic [12:0] shadow_cfg [0:4];

  int unsigned send_gap_pct;
  int unsigned stall_pct;
  logic        hold_output;
  int unsigned cycle_count;
  int unsigned items_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drive output back-pressure
  always @(negedge clk) begin
    out_stall <= hold_output || ($urandom_range(99) < stall_pct);
  end

  // Check every accepted pixel
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_pixel({chan3, chan2, chan1, chan0});
  end

  function automatic longint unsigned clampv(longint unsigned v, longint unsigned lo,
                                             longint unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] peek(longint unsigned addr);
    return image_mem[addr[bis_pkg::STORE_AW-1:0]];
  endfunction

  // Bilinear blend of one destination pixel from the shadow store
  function automatic pixel_t blend_pixel(logic [11:0] px, logic [11:0] py);
    longint unsigned sw, sh, dw, dh, nc, i, j, y0, y1, x0, x1, fx, fy;
    longint unsigned row0, row1, prod, a, b, c, d, total;
    pixel_t res;
    sw = clampv(shadow_cfg[bis_pkg::REG_SRC_WIDTH], 1, bis_pkg::SRC_MAX) - 1;
    sh = clampv(shadow_cfg[bis_pkg::REG_SRC_HEIGHT], 1, bis_pkg::SRC_MAX) - 1;
    dw = clampv(shadow_cfg[bis_pkg::REG_DST_WIDTH], 2, bis_pkg::DST_MAX) - 1;
    dh = clampv(shadow_cfg[bis_pkg::REG_DST_HEIGHT], 2, bis_pkg::DST_MAX) - 1;
    nc = clampv(shadow_cfg[bis_pkg::REG_CHANNELS], 1, bis_pkg::CH_MAX);
    j = clampv(px, 0, dw);
    i = clampv(py, 0, dh);
    y0 = (i * sh) / dh;
    fy = (i * sh) % dh;
    y1 = (fy == 0) ? y0 : y0 + 1;
    x0 = (j * sw) / dw;
    fx = (j * sw) % dw;
    x1 = (fx == 0) ? x0 : x0 + 1;
    row0 = y0 * (sw + 1) * nc;
    row1 = y1 * (sw + 1) * nc;
    prod = dw * dh;
    res = '0;
    for (int k = 0; k < bis_pkg::CH_MAX; k++) begin
      if (k < nc) begin
        a = peek(row0 + x0 * nc + k);
        b = peek(row0 + x1 * nc + k);
        c = peek(row1 + x0 * nc + k);
        d = peek(row1 + x1 * nc + k);
        total = a * (dw - fx) * (dh - fy) + b * fx * (dh - fy)
              + c * (dw - fx) * fy + d * fx * fy + prod / 2;
        res[k] = 8'(total / prod);
      end
    end
    return res;
  endfunction

  // Offer one transaction, hold it until accepted, then update the shadow
  task automatic send(bis_pkg::cmd_t cmd, logic [17:0] idx, logic [7:0] val,
                      logic [11:0] px, logic [11:0] py);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    command   = cmd;
    src_index = idx;
    src_byte  = val;
    dst_x     = px;
    dst_y     = py;
    do @(posedge clk); while (in_stall);
    if (cmd == bis_pkg::CMD_LOAD) begin
      image_mem[idx] = val;
    end else begin
      board.note_pixel(blend_pixel(px, py));
    end
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic load(logic [17:0] idx, logic [7:0] val);
    send(bis_pkg::CMD_LOAD, idx, val, 12'($urandom), 12'($urandom));
  endtask

  task automatic compute(logic [11:0] px, logic [11:0] py);
    send(bis_pkg::CMD_COMPUTE, 18'($urandom), 8'($urandom), px, py);
  endtask

  // Hold off the sender until every pixel is back and the pipe is empty
  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      bis_pkg::REG_SRC_WIDTH:  shadow_cfg[idx] = val & 13'h1FF;
      bis_pkg::REG_SRC_HEIGHT: shadow_cfg[idx] = val & 13'h1FF;
      bis_pkg::REG_DST_WIDTH:  shadow_cfg[idx] = val;
      bis_pkg::REG_DST_HEIGHT: shadow_cfg[idx] = val;
      bis_pkg::REG_CHANNELS:   shadow_cfg[idx] = val & 13'h7;
      default: ;
    endcase
  endtask

  // Reprogram the scaler and fill the whole source image
  task automatic setup(int sw, int sh, int dw, int dh, int nc);
    int bytes;
    drain();
    write_reg(bis_pkg::REG_SRC_WIDTH, 13'(sw));
    write_reg(bis_pkg::REG_SRC_HEIGHT, 13'(sh));
    write_reg(bis_pkg::REG_DST_WIDTH, 13'(dw));
    write_reg(bis_pkg::REG_DST_HEIGHT, 13'(dh));
    write_reg(bis_pkg::REG_CHANNELS, 13'(nc));
    bytes = int'(clampv(shadow_cfg[bis_pkg::REG_SRC_WIDTH], 1, bis_pkg::SRC_MAX)
               * clampv(shadow_cfg[bis_pkg::REG_SRC_HEIGHT], 1, bis_pkg::SRC_MAX)
               * clampv(shadow_cfg[bis_pkg::REG_CHANNELS], 1, bis_pkg::CH_MAX));
    for (int a = 0; a < bytes; a++) load(18'(a), 8'($urandom));
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_gap_pct = 0;  stall_pct = 0;  end
      1: begin send_gap_pct = 65; stall_pct = 0;  end
      2: begin send_gap_pct = 0;  stall_pct = 65; end
      default: begin send_gap_pct = 34; stall_pct = 34; end
    endcase
  endtask

  // Corners, pixel (1,1) and coordinates past the image
  task automatic corner_pixels();
    int dw, dh;
    dw = int'(clampv(shadow_cfg[bis_pkg::REG_DST_WIDTH], 2, bis_pkg::DST_MAX)) - 1;
    dh = int'(clampv(shadow_cfg[bis_pkg::REG_DST_HEIGHT], 2, bis_pkg::DST_MAX)) - 1;
    compute(12'd0, 12'd0);
    compute(12'(dw), 12'(dh));
    compute(12'(dw), 12'd0);
    compute(12'd0, 12'(dh));
    compute(12'hFFF, 12'hFFF);
    compute(12'd1, 12'd1);
  endtask

  // Random pixels with some stray loads anywhere in the store
  task automatic random_pixels(int count);
    int dw, dh;
    dw = int'(clampv(shadow_cfg[bis_pkg::REG_DST_WIDTH], 2, bis_pkg::DST_MAX)) - 1;
    dh = int'(clampv(shadow_cfg[bis_pkg::REG_DST_HEIGHT], 2, bis_pkg::DST_MAX)) - 1;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 15)
        load(18'($urandom), 8'($urandom));
      else if ($urandom_range(99) < 10)
        compute(12'($urandom), 12'($urandom));
      else
        compute(12'($urandom_range(dw)), 12'($urandom_range(dh)));
    end
  endtask

  initial begin
    int sw, sh, dw, dh;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = bis_pkg::REG_SRC_WIDTH;
    cfg_data    = '0;
    in_valid    = 1'b0;
    command     = bis_pkg::CMD_LOAD;
    src_index   = '0;
    src_byte    = '0;
    dst_x       = '0;
    dst_y       = '0;
    out_stall   = 1'b0;
    hold_output = 1'b0;
    cycle_count = 0;
    items_sent  = 0;
    shadow_cfg[bis_pkg::REG_SRC_WIDTH]  = 13'd256;
    shadow_cfg[bis_pkg::REG_SRC_HEIGHT] = 13'd256;
    shadow_cfg[bis_pkg::REG_DST_WIDTH]  = 13'd256;
    shadow_cfg[bis_pkg::REG_DST_HEIGHT] = 13'd256;
    shadow_cfg[bis_pkg::REG_CHANNELS]   = 13'd3;
    set_idling(0);
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed: small image, widest source row, tallest source column
    setup(4, 3, 7, 5, 3);
    drain();
    write_reg(REG_UNUSED, 13'h1FFF);
    corner_pixels();
    compute(12'd3, 12'd2);
    set_idling(3);
    setup(511, 1, 8191, 2, 1);
    corner_pixels();
    set_idling(1);
    setup(1, 256, 2, 4096, 1);
    corner_pixels();
    // Out-of-range register values
    set_idling(2);
    setup(0, 2, 1, 0, 7);
    corner_pixels();
    setup(2, 0, 4096, 1, 0);
    corner_pixels();

    // Random phases; the first one parks the receiver to fill the pipe
    for (int ph = 0; items_sent < 800; ph++) begin
      sw = $urandom_range(1, 8);
      sh = $urandom_range(1, 8);
      dw = ($urandom_range(9) == 0) ? bis_pkg::DST_MAX : $urandom_range(2, 40);
      dh = ($urandom_range(9) == 0) ? bis_pkg::DST_MAX : $urandom_range(2, 40);
      setup(sw, sh, dw, dh, $urandom_range(1, bis_pkg::CH_MAX));
      if (ph == 0) begin
        fork
          begin
            hold_output = 1'b1;
            repeat (300) @(posedge clk);
            @(negedge clk);
            hold_output = 1'b0;
          end
        join_none
      end
      set_idling(ph);
      random_pixels(40);
      set_idling(ph + 1);
      random_pixels(40);
    end

    drain();
    if (board.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
